/* rtl/tes_pkg.sv */
// Shared types, widths and codes of the timed event schedule table.
package tes_pkg;

   localparam int STAMP_W = 32;
   localparam int ENTRY_W = STAMP_W + 1;

   localparam int REQ_TYPE_W = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int STATUS_W = 3;
   localparam int RIDX_W = 4;
   localparam int COUNT_W = 5;
   localparam int DIDX_W = 4;
   localparam int RSP_TDATA_W = 16;

   localparam logic [REQ_TYPE_W-1:0] REQ_ADD = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FIRED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DELETED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd5;

   typedef struct packed {
      logic load;
      logic shift;
      logic [ENTRY_W-1:0] load_data;
   } cell_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic light_write;
      logic light_level;
      logic auto_off;
      logic [RIDX_W-1:0] removed_index;
      logic [COUNT_W-1:0] entry_count;
      logic last;
   } rsp_word_type;

endpackage

/* rtl/tes_cell.sv */
// One table slot: holds an entry, takes its upper neighbor's entry on a shift or a new one on a load.
module tes_cell #(
   parameter int INDEX_W = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  tes_pkg::cell_cmd_type         cmd,
   input  logic [INDEX_W-1:0]            load_idx,
   input  logic [INDEX_W-1:0]            shift_from,
   input  logic [tes_pkg::ENTRY_W-1:0]   next_entry,
   output logic [tes_pkg::ENTRY_W-1:0]   entry_q
);

   localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(CELL_IDX);

   logic [tes_pkg::ENTRY_W-1:0] entry_ff;
   logic [tes_pkg::ENTRY_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift && (MY_IDX >= shift_from)) begin
         entry_in = next_entry;
      end
      // a load wins over the shift so a kept entry can be parked at the tail
      if (cmd.load && (MY_IDX == load_idx)) begin
         entry_in = cmd.load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

/* rtl/tes_ctrl.sv */
// Sequencer of the schedule table: decodes words, drives the cell row and holds the result register.
module tes_ctrl #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tes_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [tes_pkg::STAMP_W-1:0]        req_stamp,
   input  logic                               req_on_level,
   input  logic [tes_pkg::DIDX_W-1:0]         req_entry_index,
   input  logic [tes_pkg::ENTRY_W-1:0]        head_entry,
   output tes_pkg::cell_cmd_type              cell_cmd,
   output logic [$clog2(ENTRIES)-1:0]         load_idx,
   output logic [$clog2(ENTRIES)-1:0]         shift_from,
   output logic                               rsp_valid,
   input  logic                               rsp_tready,
   output tes_pkg::rsp_word_type              rsp_word
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > tes_pkg::DIDX_W) ? CW : tes_pkg::DIDX_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                          state_ff, state_in;
   logic [CW-1:0]                 held_ff, held_in;
   logic [CW-1:0]                 remain_ff, remain_in;
   logic [CW-1:0]                 kept_ff, kept_in;
   logic [tes_pkg::STAMP_W-1:0]   now_ff, now_in;
   logic                          known_ff, known_in;
   logic                          out_valid_ff, out_valid_in;
   tes_pkg::rsp_word_type         out_ff, out_in;
   logic                          pend_valid_ff, pend_valid_in;
   tes_pkg::rsp_word_type         pend_ff, pend_in;

   logic                          can_out;
   logic                          accept;
   logic                          head_match;
   logic [CW-1:0]                 held_dec;
   logic [CW-1:0]                 held_inc;
   tes_pkg::rsp_word_type         pend_last;

   function automatic tes_pkg::rsp_word_type make_word(
      input logic [tes_pkg::STATUS_W-1:0] status,
      input logic                         fire,
      input logic                         level,
      input logic [tes_pkg::RIDX_W-1:0]   ridx,
      input logic [tes_pkg::COUNT_W-1:0]  count,
      input logic                         last
   );
      tes_pkg::rsp_word_type w;
      w.status = status;
      w.light_write = fire;
      w.light_level = level;
      w.auto_off = fire;
      w.removed_index = ridx;
      w.entry_count = count;
      w.last = last;
      return w;
   endfunction

   assign can_out = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && can_out;
   assign accept = req_tvalid && req_tready;
   assign head_match = (head_entry[tes_pkg::ENTRY_W-1:1] == now_ff);
   assign held_dec = held_ff - 1'b1;
   assign held_inc = held_ff + 1'b1;

   always_comb begin
      pend_last = pend_ff;
      pend_last.last = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      remain_in = remain_ff;
      kept_in = kept_ff;
      now_in = now_ff;
      known_in = known_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      cell_cmd = '0;
      load_idx = '0;
      shift_from = '0;

      if (accept) begin
         unique case (req_type)
            tes_pkg::REQ_ADD: begin
               out_valid_in = 1'b1;
               if (held_ff >= FULL_COUNT) begin
                  out_in = make_word(tes_pkg::ST_FULL, 1'b0, 1'b0, '0,
                                     tes_pkg::COUNT_W'(held_ff), 1'b1);
               end else if (known_ff && (req_stamp == now_ff)) begin
                  out_in = make_word(tes_pkg::ST_FIRED, 1'b1, req_on_level,
                                     tes_pkg::RIDX_W'(held_ff),
                                     tes_pkg::COUNT_W'(held_ff), 1'b1);
               end else begin
                  cell_cmd.load = 1'b1;
                  cell_cmd.load_data = {req_stamp, req_on_level};
                  load_idx = held_ff[IW-1:0];
                  held_in = held_inc;
                  out_in = make_word(tes_pkg::ST_ADDED, 1'b0, 1'b0, '0,
                                     tes_pkg::COUNT_W'(held_inc), 1'b1);
               end
            end
            tes_pkg::REQ_DELETE: begin
               out_valid_in = 1'b1;
               if (CMPW'(req_entry_index) < CMPW'(held_ff)) begin
                  cell_cmd.shift = 1'b1;
                  shift_from = IW'(req_entry_index);
                  held_in = held_dec;
                  out_in = make_word(tes_pkg::ST_DELETED, 1'b0, 1'b0,
                                     tes_pkg::RIDX_W'(req_entry_index),
                                     tes_pkg::COUNT_W'(held_dec), 1'b1);
               end else begin
                  out_in = make_word(tes_pkg::ST_BADIDX, 1'b0, 1'b0, '0,
                                     tes_pkg::COUNT_W'(held_ff), 1'b1);
               end
            end
            tes_pkg::REQ_TICK: begin
               now_in = req_stamp;
               known_in = 1'b1;
               remain_in = held_ff;
               kept_in = '0;
               state_in = S_SCAN;
            end
            default: begin
            end
         endcase
      end else if ((state_ff == S_SCAN) && can_out) begin
         if (remain_ff != '0) begin
            // pop the head; a kept entry goes back in at the tail
            cell_cmd.shift = 1'b1;
            remain_in = remain_ff - 1'b1;
            if (head_match) begin
               held_in = held_dec;
               pend_valid_in = 1'b1;
               pend_in = make_word(tes_pkg::ST_FIRED, 1'b1, head_entry[0],
                                   tes_pkg::RIDX_W'(kept_ff),
                                   tes_pkg::COUNT_W'(held_dec), 1'b0);
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in = pend_ff;
               end
            end else begin
               cell_cmd.load = 1'b1;
               cell_cmd.load_data = head_entry;
               load_idx = held_dec[IW-1:0];
               kept_in = kept_ff + 1'b1;
            end
         end else begin
            out_valid_in = 1'b1;
            pend_valid_in = 1'b0;
            state_in = S_IDLE;
            if (pend_valid_ff) begin
               out_in = pend_last;
            end else begin
               out_in = make_word(tes_pkg::ST_NOMATCH, 1'b0, 1'b0, '0,
                                  tes_pkg::COUNT_W'(held_ff), 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff <= '0;
         known_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         known_ff <= known_in;
         out_valid_ff <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      kept_ff <= kept_in;
      now_ff <= now_in;
      out_ff <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;

endmodule

/* rtl/timed_event_schedule_table.sv */
// Top level of the timed event schedule table: a row of entry cells behind one sequencer.
// Add and delete words give their single result word in the cycle after acceptance.
// A tick word walks the table through the head cell, one entry per cycle while the result
// register can move; each fired word is held back until the next match or the scan end.
// A new request word is taken once the sequencer is idle and the result register can move.
// Reset (synchronous) clears the entry count, the time-known flag and all valid flags;
// stored entries are not cleared and are never read before they are written.
module timed_event_schedule_table #(
   parameter int ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // on_level[32], entry_index[36:33], zero[39:37]
   input  logic [tes_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [tes_pkg::REQ_TYPE_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // light_write[0], light_level[1], auto_off[2], removed_index[6:3],
   // entry_count[11:7], zero[15:12]
   output logic [tes_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[2:0]
   output logic [tes_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IW = $clog2(ENTRIES);

   logic [tes_pkg::STAMP_W-1:0] req_stamp;
   tes_pkg::cell_cmd_type       cell_cmd;
   logic [IW-1:0]               load_idx;
   logic [IW-1:0]               shift_from;
   logic [tes_pkg::ENTRY_W-1:0] cell_q [ENTRIES];
   tes_pkg::rsp_word_type       rsp_word;

   // stamp packs year, month, day, hour, minute from the top bit down
   assign req_stamp = {req_tdata[11:0], req_tdata[15:12], req_tdata[20:16],
                       req_tdata[25:21], req_tdata[31:26]};

   tes_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_type        (req_tuser),
      .req_stamp       (req_stamp),
      .req_on_level    (req_tdata[32]),
      .req_entry_index (req_tdata[36:33]),
      .head_entry      (cell_q[0]),
      .cell_cmd        (cell_cmd),
      .load_idx        (load_idx),
      .shift_from      (shift_from),
      .rsp_valid       (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_word        (rsp_word)
   );

   for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
      logic [tes_pkg::ENTRY_W-1:0] next_entry;
      if (j == ENTRIES - 1) begin : g_tail
         assign next_entry = cell_q[j];
      end else begin : g_body
         assign next_entry = cell_q[j+1];
      end
      tes_cell #(
         .INDEX_W  (IW),
         .CELL_IDX (j)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .load_idx   (load_idx),
         .shift_from (shift_from),
         .next_entry (next_entry),
         .entry_q    (cell_q[j])
      );
   end

   assign rsp_tdata = tes_pkg::RSP_TDATA_W'({rsp_word.entry_count, rsp_word.removed_index,
                                             rsp_word.auto_off, rsp_word.light_level,
                                             rsp_word.light_write});
   assign rsp_tuser = rsp_word.status;
   assign rsp_tlast = rsp_word.last;

endmodule

/* rtl/tes_checker.sv */
// Port-level checks of the timed event schedule table, bound to the top level.
module tes_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [tes_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic [tes_pkg::REQ_TYPE_W-1:0]    req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tes_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [tes_pkg::STATUS_W-1:0]      rsp_tuser,
   input logic                              rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // only fired words drive the light and drop auto mode
   a_fire_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == tes_pkg::ST_FIRED) == (rsp_tdata[0] && rsp_tdata[2]))
                     && (rsp_tdata[0] == rsp_tdata[2]))
      else $error("light flags do not match status");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != tes_pkg::ST_FIRED) |-> rsp_tlast)
      else $error("single result word without last");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken while result register blocked");

endmodule

bind timed_event_schedule_table tes_checker u_tes_checker (.*);

/* dv/schedule_table_checker.sv */
// Checker for the timed event schedule table: tracks the table, predicts result words, compares.
module schedule_table_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // on_level[32], entry_index[36:33], zero[39:37]
   input  logic [tes_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [tes_pkg::REQ_TYPE_W-1:0]   req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // light_write[0], light_level[1], auto_off[2], removed_index[6:3],
   // entry_count[11:7], zero[15:12]
   input  logic [tes_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status[2:0]
   input  logic [tes_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               owed_count,
   output int                               failures,
   output int                               words_checked,
   output int                               fires_seen
);

   // each slot: stamp in the upper bits, light level in bit 0
   logic [tes_pkg::ENTRY_W-1:0] slots [ENTRIES];
   int unsigned                 fill;
   logic [tes_pkg::STAMP_W-1:0] tick_stamp;
   logic                        tick_seen;
   tes_pkg::rsp_word_type       owed_results [$];

   function automatic tes_pkg::rsp_word_type result_word(
      input logic [tes_pkg::STATUS_W-1:0] status,
      input logic fires, input logic level,
      input int unsigned idx, input logic last);
      tes_pkg::rsp_word_type w;
      w.status        = status;
      w.light_write   = fires;
      w.light_level   = level;
      w.auto_off      = fires;
      w.removed_index = tes_pkg::RIDX_W'(idx);
      w.entry_count   = tes_pkg::COUNT_W'(fill);
      w.last          = last;
      return w;
   endfunction

   // remove a slot and close the gap behind it
   function automatic void drop_slot(input int unsigned at);
      int unsigned j;
      for (j = at; j + 1 < fill; j++)
         slots[j] = slots[j + 1];
      fill--;
   endfunction

   task automatic advance_schedule(input logic [tes_pkg::REQ_TYPE_W-1:0] kind,
                                   input logic [tes_pkg::REQ_TDATA_W-1:0] word);
      logic [tes_pkg::STAMP_W-1:0] stamp;
      logic                        level;
      logic                        fired_level;
      int unsigned                 idx;
      int unsigned                 i;
      tes_pkg::rsp_word_type       batch [$];
      tes_pkg::rsp_word_type       w;
      stamp = {word[11:0], word[15:12], word[20:16], word[25:21], word[31:26]};
      level = word[32];
      idx   = word[36:33];
      case (kind)
         tes_pkg::REQ_ADD: begin
            if (fill >= ENTRIES) begin
               owed_results.push_back(result_word(tes_pkg::ST_FULL, 1'b0, 1'b0, 0, 1'b1));
            end else if (tick_seen && stamp == tick_stamp) begin
               // already due: fire now, keep nothing
               owed_results.push_back(result_word(tes_pkg::ST_FIRED, 1'b1, level, fill,
                                                  1'b1));
            end else begin
               slots[fill] = {stamp, level};
               fill++;
               owed_results.push_back(result_word(tes_pkg::ST_ADDED, 1'b0, 1'b0, 0, 1'b1));
            end
         end
         tes_pkg::REQ_DELETE: begin
            if (idx < fill) begin
               drop_slot(idx);
               owed_results.push_back(result_word(tes_pkg::ST_DELETED, 1'b0, 1'b0, idx,
                                                  1'b1));
            end else begin
               owed_results.push_back(result_word(tes_pkg::ST_BADIDX, 1'b0, 1'b0, 0, 1'b1));
            end
         end
         tes_pkg::REQ_TICK: begin
            tick_stamp = stamp;
            tick_seen  = 1'b1;
            i = 0;
            // do not advance past a fired slot: the next entry moves into it
            while (i < fill) begin
               if (slots[i][tes_pkg::ENTRY_W-1:1] == stamp) begin
                  fired_level = slots[i][0];
                  drop_slot(i);
                  batch.push_back(result_word(tes_pkg::ST_FIRED, 1'b1, fired_level, i,
                                              1'b0));
               end else begin
                  i++;
               end
            end
            if (batch.size() == 0) begin
               owed_results.push_back(result_word(tes_pkg::ST_NOMATCH, 1'b0, 1'b0, 0,
                                                  1'b1));
            end else begin
               foreach (batch[k]) begin
                  w = batch[k];
                  w.last = (k == batch.size() - 1);
                  owed_results.push_back(w);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic match_result();
      tes_pkg::rsp_word_type want;
      if (owed_results.size() == 0) begin
         $error("result word with nothing owed: status %0d, tdata %h", rsp_tuser, rsp_tdata);
         failures++;
      end else begin
         want = owed_results.pop_front();
         check_field("status", want.status, rsp_tuser);
         check_field("light_write", want.light_write, rsp_tdata[0]);
         check_field("light_level", want.light_level, rsp_tdata[1]);
         check_field("auto_off", want.auto_off, rsp_tdata[2]);
         check_field("removed_index", want.removed_index, rsp_tdata[6:3]);
         check_field("entry_count", want.entry_count, rsp_tdata[11:7]);
         check_field("last", want.last, rsp_tlast);
         words_checked++;
         if (want.status == tes_pkg::ST_FIRED)
            fires_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill       = 0;
         tick_stamp = '0;
         tick_seen  = 1'b0;
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            match_result();
         if (req_tvalid && req_tready)
            advance_schedule(req_tuser, req_tdata);
      end
      owed_count = owed_results.size();
   end

endmodule

/* dv/timed_event_schedule_table_tb.sv */
// Testbench top for the timed event schedule table: stimulus, flow control and verdict.
module timed_event_schedule_table_tb;

   localparam logic [tes_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [tes_pkg::STAMP_W-1:0]    STAMP_TOP = '1;
   localparam int HOLD_CYCLES = 300;
   // long receiver hold plus a full table scan, with a wide margin for random stalls
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [tes_pkg::REQ_TDATA_W-1:0]    req_tdata;
   logic [tes_pkg::REQ_TYPE_W-1:0]     req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [tes_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic [tes_pkg::STATUS_W-1:0]       rsp_tuser;
   logic                               rsp_tlast;

   int owed_count;
   int failures;
   int words_checked;
   int fires_seen;

   int send_idle_pct;
   int recv_idle_pct;
   logic hold_ask;

   int adds_sent;
   int deletes_sent;
   int ticks_sent;
   int unused_sent;
   logic [tes_pkg::STAMP_W-1:0] last_tick;
   logic [tes_pkg::STAMP_W-1:0] stamp_pool [$];

   always #5 clock = ~clock;

   timed_event_schedule_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   schedule_table_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .owed_count    (owed_count),
      .failures      (failures),
      .words_checked (words_checked),
      .fires_seen    (fires_seen)
   );

   // stamp bits from the top: year, month, day, hour, minute
   function automatic logic [tes_pkg::REQ_TDATA_W-1:0] pack_req(
      input logic [tes_pkg::STAMP_W-1:0] stamp,
      input logic level,
      input logic [tes_pkg::DIDX_W-1:0] idx);
      return {3'b000, idx, level, stamp[5:0], stamp[10:6], stamp[15:11], stamp[19:16],
              stamp[31:20]};
   endfunction

   function automatic logic [tes_pkg::STAMP_W-1:0] fresh_stamp();
      if ($urandom_range(9) == 0)
         return $urandom();
      return {12'($urandom_range(4095)), 4'($urandom_range(1, 12)),
              5'($urandom_range(1, 31)), 5'($urandom_range(23)), 6'($urandom_range(59))};
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic put_word(input logic [tes_pkg::REQ_TYPE_W-1:0] kind,
                           input logic [tes_pkg::REQ_TDATA_W-1:0] payload);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= payload;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      case (kind)
         tes_pkg::REQ_ADD:    adds_sent++;
         tes_pkg::REQ_DELETE: deletes_sent++;
         tes_pkg::REQ_TICK:   ticks_sent++;
         default:             unused_sent++;
      endcase
   endtask

   task automatic random_item();
      int pick;
      logic [tes_pkg::STAMP_W-1:0] st;
      logic [tes_pkg::DIDX_W-1:0] idx;
      pick = $urandom_range(99);
      idx  = tes_pkg::DIDX_W'($urandom_range(15));
      // reuse recent stamps so ticks find matches and several entries share a minute
      if (stamp_pool.size() != 0 && $urandom_range(99) < 60)
         st = stamp_pool[$urandom_range(stamp_pool.size() - 1)];
      else
         st = fresh_stamp();
      if (pick < 45) begin
         if ($urandom_range(9) == 0)
            st = last_tick;
         put_word(tes_pkg::REQ_ADD, pack_req(st, 1'($urandom_range(1)), idx));
         stamp_pool.push_back(st);
         if (stamp_pool.size() > 24)
            void'(stamp_pool.pop_front());
      end else if (pick < 62) begin
         if ($urandom_range(1) == 1)
            idx = tes_pkg::DIDX_W'($urandom_range(3));
         put_word(tes_pkg::REQ_DELETE, pack_req(st, 1'($urandom_range(1)), idx));
      end else if (pick < 94) begin
         put_word(tes_pkg::REQ_TICK, pack_req(st, 1'($urandom_range(1)), idx));
         last_tick = st;
      end else begin
         put_word(REQ_UNUSED, pack_req(fresh_stamp(), 1'($urandom_range(1)), idx));
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = adds_sent + deletes_sent + ticks_sent + count;
      while (adds_sent + deletes_sent + ticks_sent < target)
         random_item();
   endtask

   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int i;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = tes_pkg::REQ_ADD;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_ask      = 1'b0;
      adds_sent     = 0;
      deletes_sent  = 0;
      ticks_sent    = 0;
      unused_sent   = 0;
      last_tick     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // delete from an empty table, then fill it before any time is known
      put_word(tes_pkg::REQ_DELETE, pack_req('0, 1'b0, 4'd0));
      put_word(tes_pkg::REQ_ADD, pack_req('0, 1'b1, 4'd15));
      for (i = 1; i < 16; i++)
         put_word(tes_pkg::REQ_ADD, pack_req((i % 4 == 1) ? STAMP_TOP :
                                    {12'(2000 + i), 4'(i % 12 + 1), 5'(i + 1), 5'(i), 6'(i * 3)},
                                    i[0], tes_pkg::DIDX_W'(i)));
      put_word(tes_pkg::REQ_ADD, pack_req(STAMP_TOP, 1'b1, 4'd15));
      put_word(REQ_UNUSED, pack_req(STAMP_TOP, 1'b1, 4'd15));
      put_word(tes_pkg::REQ_DELETE, pack_req(STAMP_TOP, 1'b1, 4'd15));
      put_word(tes_pkg::REQ_DELETE, pack_req('0, 1'b0, 4'd15));
      put_word(tes_pkg::REQ_DELETE, pack_req('0, 1'b0, 4'd0));
      // all-ones minute fires several entries; zero minute then matches nothing
      put_word(tes_pkg::REQ_TICK, pack_req(STAMP_TOP, 1'b0, 4'd0));
      put_word(tes_pkg::REQ_TICK, pack_req('0, 1'b0, 4'd0));
      put_word(tes_pkg::REQ_ADD, pack_req('0, 1'b0, 4'd7));
      put_word(tes_pkg::REQ_ADD, pack_req('0, 1'b1, 4'd8));
      last_tick = '0;

      send_idle_pct = 32;
      recv_idle_pct = 79;
      run_random(45);
      send_idle_pct = 79;
      recv_idle_pct = 32;
      run_random(45);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // starve the result side so the block backs up into its input
      hold_ask = 1'b1;
      run_random(45);
      req_tvalid <= 1'b0;

      while (owed_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d adds, %0d deletes, %0d ticks and %0d unused-type words.",
               adds_sent, deletes_sent, ticks_sent, unused_sent);
      $display("Checked %0d result words, %0d of them fires.", words_checked, fires_seen);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
